### rtl/ttd_pkg.sv
// ttd_pkg: shared types, constants and control structs for the tilt to drive command block
// no dependencies; imported by ttd_lane, ttd_merge and tilt_to_drive_command
`default_nettype none

package ttd_pkg;

	// fixed-point layout
	localparam int FRAC_BITS = 8;
	localparam int SAMPLE_W  = 16;
	localparam int KEEP_W    = 9;
	localparam int GAIN_W    = 10;
	localparam int THRESH_W  = 7;
	localparam int WEIGHT_SH = 8;
	localparam int SMOOTH_W  = SAMPLE_W + FRAC_BITS + 1;
	localparam int SUM_W     = SMOOTH_W + KEEP_W + 1;
	localparam int DEV_W     = SMOOTH_W + 1;
	localparam int PROD_W    = DEV_W + GAIN_W + 1;
	localparam int SCALE_SH  = FRAC_BITS + 8;
	localparam int P_W       = PROD_W - SCALE_SH;
	localparam int Q_W       = P_W + 1;

	localparam logic [KEEP_W-1:0] KEEP_ONE = KEEP_W'(256);

	// mapping of -2000..2000 onto the command ranges
	localparam int MAP_OFFSET = 2000;
	localparam int MAP_SPAN   = 4000;
	localparam int MAP_W      = 12;
	localparam int ANGLE_NUM  = 9;
	localparam int SPEED_NUM  = 99;
	localparam int VA_W       = 16;
	localparam int VS_W       = 19;
	localparam int ANGLE_MAX  = 45;
	localparam int SPEED_MAX  = 99;

	// floor(v / 400) for v < 36000 and floor(v / 2000) for v < 396000
	localparam int RA_SH  = 24;
	localparam int RA_MUL = 41944;
	localparam int RA_W   = 32;
	localparam int RS_SH  = 28;
	localparam int RS_MUL = 134218;
	localparam int RS_W   = 37;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [KEEP_W-1:0]   KEEP_RESET   = KEEP_W'(218);
	localparam logic [GAIN_W-1:0]   X_GAIN_RESET = GAIN_W'(410);
	localparam logic [GAIN_W-1:0]   Y_GAIN_RESET = GAIN_W'(358);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(3);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_x;
		logic signed [SAMPLE_W-1:0] sample_y;
	} in_item_t;

	typedef struct packed {
		logic signed [6:0] steer_angle;
		logic [6:0]        drive_speed;
		logic              send_command;
	} out_item_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEEP,
		CFG_X_GAIN,
		CFG_Y_GAIN,
		CFG_THRESHOLD
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SCALE,
		ST_MAP,
		ST_RECIP,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic sum_en;
		logic scale_en;
	} lane_ctl_t;

	typedef struct packed {
		logic map_en;
		logic recip_en;
		logic out_en;
	} merge_ctl_t;

endpackage

`default_nettype wire

### rtl/ttd_lane.sv
// ttd_lane: one axis lane, exponential smoother, offset removal and gain scaling
// depends on ttd_pkg
`default_nettype none

module ttd_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ttd_pkg::lane_ctl_t                ctl,
	input  logic signed [ttd_pkg::SAMPLE_W-1:0] sample,
	input  logic [ttd_pkg::KEEP_W-1:0]        keep,
	input  logic [ttd_pkg::GAIN_W-1:0]        gain,
	output logic signed [ttd_pkg::P_W-1:0]    scaled
);
	import ttd_pkg::*;

	logic [KEEP_W-1:0]          keep_eff;
	logic [KEEP_W-1:0]          keep_inv;
	logic signed [SMOOTH_W-1:0] fresh;
	logic signed [SUM_W-1:0]    old_term_s1;
	logic signed [SUM_W-1:0]    new_term_s1;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SMOOTH_W-1:0] smooth_q;
	logic signed [SAMPLE_W-1:0] offset_q;
	logic signed [DEV_W-1:0]    dev;
	logic signed [PROD_W-1:0]   prod_s2;
	logic [PROD_W-1:0]          round_add;
	logic [PROD_W-1:0]          prod_adj;

	// keep above 1.0 holds the smoother
	assign keep_eff = (keep > KEEP_ONE) ? KEEP_ONE : keep;
	assign keep_inv = KEEP_ONE - keep_eff;

	assign fresh = {{(SMOOTH_W-SAMPLE_W-FRAC_BITS){sample[SAMPLE_W-1]}}, sample,
		{FRAC_BITS{1'b0}}};

	assign sum = old_term_s1 + new_term_s1;

	assign dev = $signed({smooth_q[SMOOTH_W-1], smooth_q})
		- $signed({{(DEV_W-SAMPLE_W-FRAC_BITS){offset_q[SAMPLE_W-1]}}, offset_q,
		{FRAC_BITS{1'b0}}});

	// bias negatives so the shift truncates toward zero
	assign round_add = prod_s2[PROD_W-1] ?
		{{(PROD_W-SCALE_SH){1'b0}}, {SCALE_SH{1'b1}}} : '0;
	assign prod_adj  = prod_s2 + round_add;
	assign scaled    = $signed(prod_adj[PROD_W-1:SCALE_SH]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			smooth_q <= '0;
		end else if (ctl.load) begin
			offset_q <= sample;
			smooth_q <= fresh;
		end else if (ctl.sum_en) begin
			// arithmetic shift is a floor
			smooth_q <= sum[SMOOTH_W+WEIGHT_SH-1:WEIGHT_SH];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			old_term_s1 <= $signed({1'b0, keep_eff}) * smooth_q;
			new_term_s1 <= $signed({1'b0, keep_inv}) * fresh;
		end
		if (ctl.scale_en) begin
			prod_s2 <= dev * $signed({1'b0, gain});
		end
	end

endmodule

`default_nettype wire

### rtl/ttd_merge.sv
// ttd_merge: maps the two lane results to angle and speed and decides on sending
// depends on ttd_pkg
`default_nettype none

module ttd_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ttd_pkg::merge_ctl_t              ctl,
	input  logic signed [ttd_pkg::P_W-1:0]   px,
	input  logic signed [ttd_pkg::P_W-1:0]   py,
	input  logic [ttd_pkg::THRESH_W-1:0]     threshold,
	output ttd_pkg::out_item_t               result
);
	import ttd_pkg::*;

	logic signed [Q_W-1:0] qx;
	logic signed [Q_W-1:0] qy;
	logic                  lo_a;
	logic                  hi_a;
	logic                  lo_s;
	logic                  hi_s;
	logic [VA_W-1:0]       va_s1;
	logic [VS_W-1:0]       vs_s1;
	logic                  lo_a_s1;
	logic                  hi_a_s1;
	logic                  lo_s_s1;
	logic                  hi_s_s1;
	logic [RA_W-1:0]       ra_s2;
	logic [RS_W-1:0]       rs_s2;
	logic                  lo_a_s2;
	logic                  hi_a_s2;
	logic                  lo_s_s2;
	logic                  hi_s_s2;
	logic [6:0]            angle_raw;
	logic [7:0]            speed_raw;
	logic signed [6:0]     angle;
	logic [6:0]            speed;
	logic signed [6:0]     sent_angle_q;
	logic [6:0]            sent_speed_q;
	logic [7:0]            diff_a;
	logic [7:0]            diff_s;
	logic [7:0]            abs_a;
	logic [7:0]            abs_s;
	logic                  send;

	assign qx   = Q_W'(px) + Q_W'(MAP_OFFSET);
	assign qy   = Q_W'(py) + Q_W'(MAP_OFFSET);
	assign lo_a = qx[Q_W-1];
	assign hi_a = !qx[Q_W-1] && (qx >= Q_W'(MAP_SPAN));
	assign lo_s = qy[Q_W-1];
	assign hi_s = !qy[Q_W-1] && (qy >= Q_W'(MAP_SPAN));

	always_ff @(posedge clk) begin
		if (ctl.map_en) begin
			va_s1   <= VA_W'(qx[MAP_W-1:0]) * VA_W'(ANGLE_NUM);
			vs_s1   <= VS_W'(qy[MAP_W-1:0]) * VS_W'(SPEED_NUM);
			lo_a_s1 <= lo_a;
			hi_a_s1 <= hi_a;
			lo_s_s1 <= lo_s;
			hi_s_s1 <= hi_s;
		end
		if (ctl.recip_en) begin
			// divide by constant through the reciprocal
			ra_s2   <= RA_W'(va_s1) * RA_W'(RA_MUL);
			rs_s2   <= RS_W'(vs_s1) * RS_W'(RS_MUL);
			lo_a_s2 <= lo_a_s1;
			hi_a_s2 <= hi_a_s1;
			lo_s_s2 <= lo_s_s1;
			hi_s_s2 <= hi_s_s1;
		end
	end

	assign angle_raw = ra_s2[RA_SH+6:RA_SH];
	assign speed_raw = rs_s2[RS_SH+7:RS_SH];

	always_comb begin
		priority if (lo_a_s2) begin
			angle = -7'(ANGLE_MAX);
		end else if (hi_a_s2) begin
			angle = 7'(ANGLE_MAX);
		end else begin
			angle = $signed(angle_raw - 7'(ANGLE_MAX));
		end
	end

	always_comb begin
		priority if (lo_s_s2 || (!hi_s_s2 && speed_raw < 8'(SPEED_MAX))) begin
			speed = '0;
		end else if (hi_s_s2) begin
			speed = 7'(SPEED_MAX);
		end else begin
			speed = 7'(speed_raw - 8'(SPEED_MAX));
		end
	end

	assign diff_a = {angle[6], angle} - {sent_angle_q[6], sent_angle_q};
	assign diff_s = {1'b0, speed} - {1'b0, sent_speed_q};
	assign abs_a  = diff_a[7] ? -diff_a : diff_a;
	assign abs_s  = diff_s[7] ? -diff_s : diff_s;
	assign send   = (abs_a >= {1'b0, threshold}) || (abs_s >= {1'b0, threshold});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_angle_q <= '0;
			sent_speed_q <= '0;
		end else if (ctl.out_en && send) begin
			sent_angle_q <= angle;
			sent_speed_q <= speed;
		end
	end

	assign result.steer_angle  = angle;
	assign result.drive_speed  = speed;
	assign result.send_command = send;

endmodule

`default_nettype wire

### rtl/tilt_to_drive_command.sv
// tilt_to_drive_command: top level, config registers, sequencer, two axis lanes and merge
// depends on ttd_pkg, ttd_lane, ttd_merge
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  in_data (sample_x, sample_y)
// out      out  out_valid / out_stall out_data (steer_angle, drive_speed, send_command)
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// the first request after reset only captures the offset
// every later request goes through smoother multiply, accumulate, gain multiply,
// range mapping, reciprocal multiply and the send decision, run in order by the sequencer
// the result lands in an output register in the send decision step; a held
// out_stall keeps the sequencer in its last step until the register frees up
// reset clears the registers to their defaults and the calibration flag
`default_nettype none

module tilt_to_drive_command (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ttd_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ttd_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ttd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ttd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ttd_pkg::*;

	seq_state_t          state_q;
	seq_state_t          state_next;
	logic                calibrated_q;
	logic                accept;
	logic                out_free;
	lane_ctl_t           lane_ctl;
	merge_ctl_t          merge_ctl;
	logic [KEEP_W-1:0]   keep_q;
	logic [GAIN_W-1:0]   x_gain_q;
	logic [GAIN_W-1:0]   y_gain_q;
	logic [THRESH_W-1:0] thresh_q;
	logic signed [P_W-1:0] px;
	logic signed [P_W-1:0] py;
	out_item_t           result;
	out_item_t           out_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q   <= KEEP_RESET;
			x_gain_q <= X_GAIN_RESET;
			y_gain_q <= Y_GAIN_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_KEEP:      keep_q   <= cfg_data[KEEP_W-1:0];
				CFG_X_GAIN:    x_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_Y_GAIN:    y_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && calibrated_q) state_next = ST_SUM;
			ST_SUM:   state_next = ST_SCALE;
			ST_SCALE: state_next = ST_MAP;
			ST_MAP:   state_next = ST_RECIP;
			ST_RECIP: state_next = ST_OUT;
			ST_OUT:   if (out_free) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall           = (state_q != ST_IDLE);
		lane_ctl.load      = in_valid && (state_q == ST_IDLE) && !calibrated_q;
		lane_ctl.start     = in_valid && (state_q == ST_IDLE) && calibrated_q;
		lane_ctl.sum_en    = (state_q == ST_SUM);
		lane_ctl.scale_en  = (state_q == ST_SCALE);
		merge_ctl.map_en   = (state_q == ST_MAP);
		merge_ctl.recip_en = (state_q == ST_RECIP);
		merge_ctl.out_en   = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			calibrated_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (lane_ctl.load) begin
				calibrated_q <= 1'b1;
			end
		end
	end

	ttd_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (in_data.sample_x),
		.keep   (keep_q),
		.gain   (x_gain_q),
		.scaled (px)
	);

	ttd_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (in_data.sample_y),
		.keep   (keep_q),
		.gain   (y_gain_q),
		.scaled (py)
	);

	ttd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (merge_ctl),
		.px        (px),
		.py        (py),
		.threshold (thresh_q),
		.result    (result)
	);

	// output register parts the result from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (merge_ctl.out_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge_ctl.out_en) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
